// ----- src/cdti64_pkg.sv -----
// Shared types and constants for the canonical decimal to 64-bit integer parser.
package cdti64_pkg;

  // What one character word means to the accumulator.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_MINUS,
    KIND_DIGIT,
    KIND_OTHER
  } char_kind_t;

  // One classified word as it travels from the front end to the back end.
  typedef struct packed {
    char_kind_t kind;
    logic [3:0] digit;
    logic       signed_mode;
    logic       last;
  } char_entry_t;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int VALUE_W = 64;

endpackage

// ----- src/cdti64_front.sv -----
// Front end: takes character words and classifies each one for the back end.
module cdti64_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [7:0]               char_code,
  input  logic                     char_present,
  input  logic                     last_char,
  input  logic                     signed_mode,
  output cdti64_pkg::char_entry_t  entry
);

  // Set once the current text has delivered a character.
  logic chars_seen;
  logic is_digit;
  logic [7:0] digit_wide;

  assign is_digit   = (char_code >= cdti64_pkg::CHAR_ZERO) &&
                      (char_code <= cdti64_pkg::CHAR_NINE);
  assign digit_wide = char_code - cdti64_pkg::CHAR_ZERO;

  always_comb begin
    entry.digit       = digit_wide[3:0];
    entry.signed_mode = signed_mode;
    entry.last        = last_char;
    if (!char_present) begin
      entry.kind = cdti64_pkg::KIND_NONE;
    end else if (!chars_seen && signed_mode && (char_code == cdti64_pkg::CHAR_MINUS)) begin
      entry.kind = cdti64_pkg::KIND_MINUS;
    end else if (is_digit) begin
      entry.kind = cdti64_pkg::KIND_DIGIT;
    end else begin
      entry.kind = cdti64_pkg::KIND_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_seen <= 1'b0;
    end else if (accept) begin
      if (last_char) begin
        chars_seen <= 1'b0;
      end else if (char_present) begin
        chars_seen <= 1'b1;
      end
    end
  end

endmodule

// ----- src/cdti64_queue.sv -----
// Small FIFO of classified words between the front end and the back end.
module cdti64_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  cdti64_pkg::char_entry_t  wr_data,
  output logic                     full,
  input  logic                     rd_en,
  output logic                     rd_valid,
  output cdti64_pkg::char_entry_t  rd_data
);

  cdti64_pkg::char_entry_t mem [cdti64_pkg::QUEUE_DEPTH];
  logic [cdti64_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [cdti64_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [cdti64_pkg::QUEUE_AW:0]   count;
  logic do_wr;
  logic do_rd;

  assign full     = (count == (cdti64_pkg::QUEUE_AW+1)'(cdti64_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/cdti64_back.sv -----
// Back end: accumulates digits, checks range and form, and drives the result word.
module cdti64_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  cdti64_pkg::char_entry_t  q_data,
  output logic                     q_pop,
  output logic                     finish_valid,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [63:0]              m_tdata,
  output logic                     m_tuser
);

  typedef struct packed {
    logic [cdti64_pkg::VALUE_W-1:0] magnitude;
    logic                           is_negative;
    logic                           failed;
    logic                           have_digit;
  } finish_t;

  localparam int SUM_W = cdti64_pkg::VALUE_W + 4;
  localparam logic [SUM_W-1:0] LIMIT_NEG  = SUM_W'(1) << (cdti64_pkg::VALUE_W - 1);
  localparam logic [SUM_W-1:0] LIMIT_POS  = LIMIT_NEG - SUM_W'(1);
  localparam logic [SUM_W-1:0] LIMIT_UNS  = (SUM_W'(1) << cdti64_pkg::VALUE_W) - SUM_W'(1);

  // Accumulator state for the text in progress.
  logic [cdti64_pkg::VALUE_W-1:0] magnitude, magnitude_next;
  logic is_negative, is_negative_next;
  logic failed, failed_next;
  logic have_digit, have_digit_next;
  logic first_zero, first_zero_next;

  logic [SUM_W-1:0] mag_wide;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] limit;
  logic fail_mid;

  finish_t finish;
  logic    out_load;
  logic    finish_free;
  logic    ok;

  assign mag_wide = {4'b0, magnitude};
  assign sum      = (mag_wide << 3) + (mag_wide << 1) + {{(SUM_W-4){1'b0}}, q_data.digit};
  assign limit    = is_negative ? LIMIT_NEG : (q_data.signed_mode ? LIMIT_POS : LIMIT_UNS);
  assign fail_mid = failed || (have_digit && first_zero);

  always_comb begin
    magnitude_next   = magnitude;
    is_negative_next = is_negative;
    failed_next      = failed;
    have_digit_next  = have_digit;
    first_zero_next  = first_zero;
    case (q_data.kind)
      cdti64_pkg::KIND_MINUS: begin
        is_negative_next = 1'b1;
      end
      cdti64_pkg::KIND_DIGIT: begin
        have_digit_next = 1'b1;
        first_zero_next = have_digit ? first_zero : (q_data.digit == 4'd0);
        failed_next     = fail_mid;
        if (!fail_mid) begin
          if (sum > limit) begin
            failed_next = 1'b1;
          end else begin
            magnitude_next = sum[cdti64_pkg::VALUE_W-1:0];
          end
        end
      end
      cdti64_pkg::KIND_OTHER: begin
        failed_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // A last word may leave only when the finish register can take it.
  assign out_load    = finish_valid && (!m_tvalid || m_tready);
  assign finish_free = !finish_valid || out_load;
  assign q_pop       = q_valid && (!q_data.last || finish_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude   <= '0;
      is_negative <= 1'b0;
      failed      <= 1'b0;
      have_digit  <= 1'b0;
      first_zero  <= 1'b0;
    end else if (q_pop) begin
      if (q_data.last) begin
        magnitude   <= '0;
        is_negative <= 1'b0;
        failed      <= 1'b0;
        have_digit  <= 1'b0;
        first_zero  <= 1'b0;
      end else begin
        magnitude   <= magnitude_next;
        is_negative <= is_negative_next;
        failed      <= failed_next;
        have_digit  <= have_digit_next;
        first_zero  <= first_zero_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finish_valid <= 1'b0;
    end else if (q_pop && q_data.last) begin
      finish_valid <= 1'b1;
    end else if (out_load) begin
      finish_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.last) begin
      finish.magnitude   <= magnitude_next;
      finish.is_negative <= is_negative_next;
      finish.failed      <= failed_next;
      finish.have_digit  <= have_digit_next;
    end
  end

  // A negative zero is not canonical.
  assign ok = !finish.failed && finish.have_digit &&
              !(finish.is_negative && (finish.magnitude == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= ok;
      if (!ok) begin
        m_tdata <= '0;
      end else if (finish.is_negative) begin
        m_tdata <= '0 - finish.magnitude;
      end else begin
        m_tdata <= finish.magnitude;
      end
    end
  end

endmodule

// ----- src/canonical_decimal_to_int64.sv -----
// Top level of the canonical decimal text to 64-bit integer parser.
//
//   Channel   Direction  Handshake           Contents
//   s_*       in         s_tvalid/s_tready   one character word of the text
//   m_*       out        m_tvalid/m_tready   one result word per text
//   cfg_*     in         cfg_wr_en           signed_mode register
//
// Character words are taken one per cycle while the four-entry queue has room.
// The back end retires one queued word per cycle unless a last word waits for
// the finish register; its digit step is a multiply by ten (two shifts and an
// add) followed by a range compare. A result passes the finish register and
// the output register; the next text streams in without a gap even while one
// result waits; with two results waiting, the queue fills up to four words.
// Reset is synchronous and clears the register, the queue and all text state.
// A stall on m_tready backs up through the finish register and the queue
// into s_tready.
module canonical_decimal_to_int64 (
  input  logic        clk,
  input  logic        rst,
  // Configuration: signed_mode is written when cfg_wr_en is high.
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tuser,   // [0] char_present
  input  logic        s_tlast,   // last_char
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] value_bits
  output logic        m_tuser    // [0] valid_res
);

  logic signed_mode;
  logic accept;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic finish_valid;
  cdti64_pkg::char_entry_t front_entry;
  cdti64_pkg::char_entry_t q_data;

  // The mode register; words are judged by the mode in force when they arrive.
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      signed_mode <= cfg_wr_data;
    end
  end

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  cdti64_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_code    (s_tdata),
    .char_present (s_tuser),
    .last_char    (s_tlast),
    .signed_mode  (signed_mode),
    .entry        (front_entry)
  );

  cdti64_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_data  (front_entry),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  cdti64_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .finish_valid (finish_valid),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser)
  );

  // A rejected text always reads as zero.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("rejected result carries a nonzero value");

  // A new result is always preceded by a finished text in the finish register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(finish_valid))
    else $error("result word appeared without a finished text");

  // Nothing is presented in the first cycle after reset.
  assert property (@(posedge clk)
    rst |=> (!m_tvalid && !finish_valid))
    else $error("output pipeline not empty after reset");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the canonical decimal to 64-bit integer parser.
`timescale 1ns / 100ps

module testbench;

  // Codes used to build texts and to set the parse mode.
  localparam logic [7:0] CHAR_PLUS      = 8'h2B;
  localparam logic [7:0] CHAR_LETTER_A  = 8'h61;
  localparam logic       MODE_UNSIGNED  = 1'b0;
  localparam logic       MODE_SIGNED    = 1'b1;

  // Limits that a magnitude may reach, depending on sign and mode.
  localparam logic [63:0] UNSIGNED_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SIGNED_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEGATIVE_MAX  = 64'h8000_0000_0000_0000;

  // A result leaves through the finish and output registers, and the input
  // queue holds four words, so this covers any word still in flight.
  localparam int SETTLE_CYCLES = 12;

  // One result word: the parsed value and whether the text was accepted.
  typedef struct packed {
    logic [63:0] value;
    logic        ok;
  } parse_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] char_code
  logic        s_tuser;   // [0] char_present
  logic        s_tlast;   // last_char
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // [63:0] value_bits
  logic        m_tuser;   // [0] valid_res

  canonical_decimal_to_int64 dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  // Idle rates in percent for the sending and receiving side.
  int send_idle_pct;
  int recv_idle_pct;

  // Mirror of the parser state. It is updated at the edge where a word is
  // taken, so it always reflects the words the block has accepted so far.
  logic        mode_q;
  logic [63:0] run_magnitude;
  logic        run_negative;
  logic        run_failed;
  logic        run_started;
  logic [1:0]  run_digits;
  logic        run_lead_zero;

  parse_result_t pending_results[$];
  logic [7:0]    text_buf[$];
  int            words_taken;
  int            mismatch_count;

  // The clock runs free for the whole simulation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  // The receiving side decides at every falling edge whether it takes a
  // result word in the coming cycle.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Appends one character to the text being built.
  function automatic void add_char(logic [7:0] code);
    text_buf.insert(text_buf.size(), code);
  endfunction

  // Clears the mirror once a text has produced its result.
  function automatic void clear_run();
    run_magnitude = '0;
    run_negative  = 1'b0;
    run_failed    = 1'b0;
    run_started   = 1'b0;
    run_digits    = '0;
    run_lead_zero = 1'b0;
  endfunction

  // Folds one character into the running magnitude. A minus sign counts only
  // as the very first character and only in signed mode; every digit is
  // checked against the limit that the sign and the current mode allow.
  function automatic void parse_char(logic [7:0] code);
    logic [63:0] digit;
    logic [63:0] limit;
    if (!run_started && mode_q == MODE_SIGNED && code == cdti64_pkg::CHAR_MINUS) begin
      run_negative = 1'b1;
    end else if (code >= cdti64_pkg::CHAR_ZERO && code <= cdti64_pkg::CHAR_NINE) begin
      digit = 64'(code - cdti64_pkg::CHAR_ZERO);
      if (run_digits == 2'd0) begin
        run_lead_zero = (digit == 64'd0);
      end else if (run_lead_zero) begin
        run_failed = 1'b1;
      end
      if (run_negative) begin
        limit = NEGATIVE_MAX;
      end else if (mode_q == MODE_SIGNED) begin
        limit = SIGNED_MAX;
      end else begin
        limit = UNSIGNED_MAX;
      end
      if (!run_failed) begin
        if (run_magnitude > (limit - digit) / 64'd10) begin
          run_failed = 1'b1;
        end else begin
          run_magnitude = run_magnitude * 64'd10 + digit;
        end
      end
      if (run_digits < 2'd2) begin
        run_digits = run_digits + 2'd1;
      end
    end else begin
      run_failed = 1'b1;
    end
    run_started = 1'b1;
  endfunction

  // Works out the result word of a finished text and queues it. A text with
  // no digit, a failed text and a negative zero all give value 0, invalid.
  function automatic void close_text();
    parse_result_t res;
    res.ok = !run_failed && run_digits != 2'd0;
    if (run_negative && run_magnitude == 64'd0) begin
      res.ok = 1'b0;
    end
    if (!res.ok) begin
      res.value = '0;
    end else if (run_negative) begin
      res.value = -run_magnitude;
    end else begin
      res.value = run_magnitude;
    end
    pending_results.insert(pending_results.size(), res);
    clear_run();
  endfunction

  // Every result word taken by the receiver is compared with the oldest
  // expected one; a word with nothing expected is a failure as well.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result word: value %h ok %b", m_tdata, m_tuser);
        end
      end else begin
        if (m_tdata !== pending_results[0].value || m_tuser !== pending_results[0].ok) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: expected value %h ok %b, got value %h ok %b",
                     pending_results[0].value, pending_results[0].ok, m_tdata, m_tuser);
          end
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Offers one word at a falling edge, possibly after some idle cycles, and
  // returns at the falling edge after the word was taken. The mirror is
  // updated at the very edge of acceptance.
  task automatic send_word(logic [7:0] code, logic present, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    s_tuser  <= present;
    s_tlast  <= last;
    do begin
      @(posedge clk);
    end while (!s_tready);
    if (present) begin
      parse_char(code);
    end
    if (last) begin
      close_text();
    end
    words_taken++;
    @(negedge clk);
  endtask

  // Sends the text held in text_buf. Words without a character may be
  // slipped in between characters; the text may also end on such a word.
  // With closes low the text is left open for a later call to continue it.
  task automatic send_text(int gap_pct, logic closes, logic blank_end);
    logic last;
    for (int i = 0; i < text_buf.size(); i++) begin
      if ($urandom_range(0, 99) < gap_pct) begin
        send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      last = closes && !blank_end && (i == text_buf.size() - 1);
      send_word(text_buf[i], 1'b1, last);
    end
    if (closes && (blank_end || text_buf.size() == 0)) begin
      send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  task automatic put_string(string str);
    for (int i = 0; i < str.len(); i++) begin
      add_char(str[i]);
    end
  endtask

  // Loads a whole directed text and sends it as one closed text.
  task automatic send_string(string str, int gap_pct = 0, logic blank_end = 1'b0);
    text_buf.delete();
    put_string(str);
    send_text(gap_pct, 1'b1, blank_end);
  endtask

  // Waits until every expected result has come and the block has had time
  // to retire any word that causes no result.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the mode register while the block is idle.
  task automatic set_mode(logic mode);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mode_q = mode;
  endtask

  // Random 64-bit value of random width, so that small and huge values both
  // come up often and every bit position gets exercised.
  function automatic logic [63:0] random_value(int max_width);
    logic [63:0] v;
    int w;
    v = {$urandom, $urandom};
    w = $urandom_range(1, max_width);
    if (w < 64) begin
      v = v & ((64'd1 << w) - 64'd1);
    end
    return v;
  endfunction

  // Builds one random text in text_buf: well-formed numbers, numbers near a
  // range limit, and texts that are broken on purpose.
  task automatic build_random_text();
    int kind;
    int pick;
    logic [63:0] v;
    logic [63:0] base;
    text_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // Well-formed number, negative about half the time in signed mode.
      v = random_value(mode_q == MODE_SIGNED ? 63 : 64);
      if (mode_q == MODE_SIGNED && v != 64'd0 && $urandom_range(0, 1) == 1) begin
        add_char(cdti64_pkg::CHAR_MINUS);
      end
      put_string($sformatf("%0d", v));
    end else if (kind < 52) begin
      // Near a limit: the leading digits of the limit and a random last
      // digit, now and then one digit too many.
      pick = $urandom_range(0, 2);
      base = (pick == 0) ? UNSIGNED_MAX : (pick == 1) ? SIGNED_MAX : NEGATIVE_MAX;
      if (pick == 2) begin
        add_char(cdti64_pkg::CHAR_MINUS);
      end
      put_string($sformatf("%0d%0d", base / 64'd10, $urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0) begin
        put_string($sformatf("%0d", $urandom_range(0, 9)));
      end
    end else if (kind < 60) begin
      // Leading zeros, with or without a minus in front.
      if ($urandom_range(0, 2) == 0) begin
        add_char(cdti64_pkg::CHAR_MINUS);
      end
      repeat ($urandom_range(1, 3)) add_char(cdti64_pkg::CHAR_ZERO);
      if ($urandom_range(0, 3) != 0) begin
        put_string($sformatf("%0d", random_value(40)));
      end
    end else if (kind < 68) begin
      // Sign trouble: plus sign, lone or doubled minus, minus after a digit.
      pick = $urandom_range(0, 3);
      case (pick)
        0: begin
          add_char(CHAR_PLUS);
          put_string($sformatf("%0d", random_value(32)));
        end
        1: begin
          add_char(cdti64_pkg::CHAR_MINUS);
        end
        2: begin
          add_char(cdti64_pkg::CHAR_MINUS);
          add_char(cdti64_pkg::CHAR_MINUS);
          put_string($sformatf("%0d", random_value(16)));
        end
        default: begin
          put_string($sformatf("%0d", random_value(16)));
          add_char(cdti64_pkg::CHAR_MINUS);
          put_string($sformatf("%0d", random_value(16)));
        end
      endcase
    end else if (kind < 78) begin
      // Noise over the whole character range.
      repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
    end else if (kind < 84) begin
      // Empty text: nothing is loaded.
    end else begin
      // A number with one random character dropped in somewhere.
      put_string($sformatf("%0d", random_value(64)));
      pick = $urandom_range(0, text_buf.size());
      text_buf.insert(pick, 8'($urandom_range(0, 255)));
    end
  endtask

  // Limits of the unsigned range, leading zeros, signs and the empty text.
  task automatic test_unsigned_limits();
    set_mode(MODE_UNSIGNED);
    send_string("0");
    send_string("18446744073709551615");
    send_string("18446744073709551616");
    send_string("00");
    send_string("007");
    send_string("-5");
    send_string("+5");
    send_string("12a");
    send_string("");
  endtask

  // Limits of the signed range, negative zero and a lone minus.
  task automatic test_signed_limits();
    set_mode(MODE_SIGNED);
    send_string("9223372036854775807");
    send_string("9223372036854775808");
    send_string("-9223372036854775808");
    send_string("-9223372036854775809");
    send_string("-0");
    send_string("-");
    send_string("-01");
    send_string("5-3");
    send_string("--1");
  endtask

  // Words without a character inside a text are skipped, and a text may end
  // on one; characters after a failure are consumed and the next text
  // starts clean.
  task automatic test_blank_words();
    send_string("42", 100);
    send_string("-17", 50, 1'b1);
    send_string("9x99999999999999999999");
    send_string("123");
  endtask

  // The mode is judged per character: a minus taken in signed mode keeps
  // the negative limit after a switch, and a minus after a digit fails.
  task automatic test_mode_switch();
    set_mode(MODE_SIGNED);
    text_buf.delete();
    put_string("-");
    send_text(0, 1'b0, 1'b0);
    set_mode(MODE_UNSIGNED);
    send_string("9223372036854775808");
    text_buf.delete();
    put_string("1");
    send_text(0, 1'b0, 1'b0);
    set_mode(MODE_SIGNED);
    send_string("-");
    set_mode(MODE_SIGNED);
    text_buf.delete();
    put_string("1");
    send_text(0, 1'b0, 1'b0);
    set_mode(MODE_UNSIGNED);
    send_string("8446744073709551615");
  endtask

  // One stretch of random texts under a fixed mode and idle pattern.
  task automatic test_random_texts(logic mode, int send_pct, int recv_pct, int n_words);
    int stop_at;
    int gap_pct;
    set_mode(mode);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = words_taken + n_words;
    while (words_taken < stop_at) begin
      build_random_text();
      gap_pct = ($urandom_range(0, 9) == 0) ? 25 : 0;
      send_text(gap_pct, 1'b1, $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    int guard;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 1'b0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = 1'b0;
    s_tlast        = 1'b0;
    send_idle_pct  = 34;
    recv_idle_pct  = 66;
    mode_q         = MODE_UNSIGNED;
    words_taken    = 0;
    mismatch_count = 0;
    clear_run();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, under the first idle pattern.
    test_unsigned_limits();
    test_signed_limits();
    test_blank_words();
    test_mode_switch();

    // Random part: sender idles little and receiver much, then the reverse,
    // then no idling at all in both modes.
    test_random_texts(MODE_SIGNED, 34, 66, 160);
    test_random_texts(MODE_UNSIGNED, 66, 34, 160);
    test_random_texts(MODE_SIGNED, 0, 0, 80);
    test_random_texts(MODE_UNSIGNED, 0, 0, 80);

    // Drain with a bound; whatever is still expected afterwards is a failure.
    s_tvalid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    mismatch_count += pending_results.size();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
